### rtl/rau_pkg.sv
// rau_pkg: opcodes and controller/datapath command and status types
// used by the rational arithmetic unit modules; no dependencies
package rau_pkg;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_EQ       = 4'd4,
        OP_NE       = 4'd5,
        OP_LT       = 4'd6,
        OP_LE       = 4'd7,
        OP_GT       = 4'd8,
        OP_GE       = 4'd9,
        OP_SIMPLIFY = 4'd10
    } opcode_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic is_defined;
        logic is_simplify;
        logic trivial;
        logic gcd_done;
    } sts_t;

endpackage

### rtl/rau_if.sv
// rau_if: valid/ready channels carrying the request and result words
// depends on nothing
interface rau_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic              truth;
    logic              fault;

    modport source (output valid, res_num, res_den, truth, fault, input ready);
    modport sink   (input valid, res_num, res_den, truth, fault, output ready);
endinterface

### rtl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: one request word in, one result word out. Add, subtract,
// multiply, divide and compare run the four cross products through one shared
// WIDTH x WIDTH multiplier. Simplify runs a binary gcd (one shift or subtract per
// cycle; every subtract leaves an even value that a later cycle shifts) and then two
// restoring dividers in parallel; trivial simplify cases skip the gcd and the dividers.
// One request is in flight at a time; a finished result waits in the output register.
// Depends on rau_pkg, rau_if, rau_ctrl and rau_dp.
module rational_arithmetic_unit_core #(
    parameter int WIDTH = 32
) (
    input logic      clk,
    input logic      rst_n,
    rau_in_if.sink   in_ch,
    rau_out_if.source out_ch
);
    rau_pkg::cmd_t cmd;
    rau_pkg::sts_t sts;

    rau_ctrl #(.WIDTH(WIDTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rau_dp #(.WIDTH(WIDTH)) u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .sts     (sts),
        .opcode  (in_ch.opcode),
        .a_num   (in_ch.a_num),
        .a_den   (in_ch.a_den),
        .b_num   (in_ch.b_num),
        .b_den   (in_ch.b_den),
        .res_num (out_ch.res_num),
        .res_den (out_ch.res_den),
        .truth   (out_ch.truth),
        .fault   (out_ch.fault)
    );

`ifndef SYNTH
    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while busy");

    // compare results carry a zero fraction
    a_truth_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.truth) |-> (out_ch.res_num == 0 && out_ch.res_den == 0))
        else $error("compare result with nonzero fraction");

    // fault only on simplify with zero denominator
    a_fault_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.fault) |-> (!out_ch.truth && out_ch.res_den == 0))
        else $error("fault with inconsistent result");
`endif

endmodule

### rtl/rau_ctrl.sv
// rau_ctrl: sequencing state machine and handshake control
// depends on rau_pkg
module rau_ctrl #(
    parameter int WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  rau_pkg::sts_t sts,
    output rau_pkg::cmd_t cmd
);
    localparam int KW = $clog2(WIDTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_GCD   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      mul_cnt_reg, mul_cnt_next;
    logic [KW-1:0]   div_cnt_reg, div_cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        mul_cnt_next   = mul_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!sts.is_defined)
                begin
                    state_next = ST_FIN;
                end
                else if (sts.is_simplify)
                begin
                    if (sts.trivial)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.gcd_init = 1'b1;
                        state_next   = ST_GCD;
                    end
                end
                else
                begin
                    mul_cnt_next = '0;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = mul_cnt_reg;
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd3)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == KW'(WIDTH - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_cnt_reg   <= mul_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/rau_dp.sv
// rau_dp: operand registers, shared multiplier, binary gcd and serial dividers
// depends on rau_pkg
module rau_dp #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  rau_pkg::cmd_t      cmd,
    output rau_pkg::sts_t      sts,
    input  logic [3:0]         opcode,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic signed [31:0] res_num,
    output logic signed [31:0] res_den,
    output logic               truth,
    output logic               fault
);
    localparam int W2 = 2 * WIDTH;
    localparam int KW = $clog2(WIDTH);

    logic [3:0]              op_reg;
    logic signed [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W2-1:0]    p_reg [4];
    logic signed [WIDTH-1:0] mul_a, mul_b;

    logic [WIDTH-1:0] u_reg, v_reg, u_next, v_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [WIDTH-1:0] nm_reg, dm_reg, g_reg;
    logic             neg_reg;
    logic [WIDTH:0]   rem1_reg, rem2_reg, rem1_next, rem2_next, trial1, trial2;
    logic [WIDTH-1:0] q1_reg, q2_reg, q1_next, q2_next;

    logic [WIDTH-1:0] n_sign, d_sign, n_mag;

    logic signed [WIDTH-1:0] rn_w, rd_w;
    logic                    tr_w, ft_w, eq_w, lt_w, gt_w;

    logic signed [31:0] res_num_reg, res_den_reg;
    logic               truth_reg, fault_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            2'd0:    begin mul_a = an_reg; mul_b = bd_reg; end
            2'd1:    begin mul_a = ad_reg; mul_b = bn_reg; end
            2'd2:    begin mul_a = ad_reg; mul_b = bd_reg; end
            default: begin mul_a = an_reg; mul_b = bn_reg; end
        endcase
    end

    always_comb
    begin
        n_sign = ad_reg[WIDTH-1] ? WIDTH'(-an_reg) : an_reg;
        d_sign = ad_reg[WIDTH-1] ? WIDTH'(-ad_reg) : ad_reg;
        n_mag  = n_sign[WIDTH-1] ? WIDTH'(-n_sign) : n_sign;
    end

    always_comb
    begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0])
        begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        else if (!u_reg[0])
        begin
            u_next = u_reg >> 1;
        end
        else if (!v_reg[0])
        begin
            v_next = v_reg >> 1;
        end
        else if (u_reg >= v_reg)
        begin
            u_next = u_reg - v_reg;
        end
        else
        begin
            v_next = v_reg - u_reg;
        end
    end

    always_comb
    begin
        trial1 = {rem1_reg[WIDTH-1:0], q1_reg[WIDTH-1]};
        trial2 = {rem2_reg[WIDTH-1:0], q2_reg[WIDTH-1]};
        rem1_next = trial1;
        rem2_next = trial2;
        q1_next = {q1_reg[WIDTH-2:0], 1'b0};
        q2_next = {q2_reg[WIDTH-2:0], 1'b0};
        if (trial1 >= {1'b0, g_reg})
        begin
            rem1_next  = trial1 - {1'b0, g_reg};
            q1_next[0] = 1'b1;
        end
        if (trial2 >= {1'b0, g_reg})
        begin
            rem2_next  = trial2 - {1'b0, g_reg};
            q2_next[0] = 1'b1;
        end
    end

    always_comb
    begin
        eq_w = (an_reg == bn_reg) && (ad_reg == bd_reg);
        lt_w = p_reg[0] < p_reg[1];
        gt_w = p_reg[1] < p_reg[0];
        rn_w = '0;
        rd_w = '0;
        tr_w = 1'b0;
        ft_w = 1'b0;
        case (op_reg)
            rau_pkg::OP_ADD:
            begin
                rn_w = p_reg[0][WIDTH-1:0] + p_reg[1][WIDTH-1:0];
                rd_w = p_reg[2][WIDTH-1:0];
            end
            rau_pkg::OP_SUB:
            begin
                rn_w = p_reg[0][WIDTH-1:0] - p_reg[1][WIDTH-1:0];
                rd_w = p_reg[2][WIDTH-1:0];
            end
            rau_pkg::OP_MUL:
            begin
                if ((an_reg == '0 && ad_reg == WIDTH'(1)) ||
                    (bn_reg == '0 && bd_reg == WIDTH'(1)))
                begin
                    rd_w = WIDTH'(1);
                end
                else
                begin
                    rn_w = p_reg[3][WIDTH-1:0];
                    rd_w = p_reg[2][WIDTH-1:0];
                end
            end
            rau_pkg::OP_DIV:
            begin
                rn_w = p_reg[0][WIDTH-1:0];
                rd_w = p_reg[1][WIDTH-1:0];
            end
            rau_pkg::OP_EQ: tr_w = eq_w;
            rau_pkg::OP_NE: tr_w = !eq_w;
            rau_pkg::OP_LT: tr_w = lt_w;
            rau_pkg::OP_LE: tr_w = lt_w || eq_w;
            rau_pkg::OP_GT: tr_w = gt_w;
            rau_pkg::OP_GE: tr_w = gt_w || eq_w;
            rau_pkg::OP_SIMPLIFY:
            begin
                if (an_reg == '0)
                begin
                    rd_w = WIDTH'(1);
                end
                else if (ad_reg == WIDTH'(1) || ad_reg == '0)
                begin
                    rn_w = an_reg;
                    rd_w = ad_reg;
                    ft_w = (ad_reg == '0);
                end
                else
                begin
                    rn_w = neg_reg ? WIDTH'(-q1_reg) : q1_reg;
                    rd_w = q2_reg;
                end
            end
            default:
            begin
                rn_w = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            an_reg <= a_num[WIDTH-1:0];
            ad_reg <= a_den[WIDTH-1:0];
            bn_reg <= b_num[WIDTH-1:0];
            bd_reg <= b_den[WIDTH-1:0];
        end
        if (cmd.mul_en)
        begin
            p_reg[cmd.mul_sel] <= W2'(mul_a) * W2'(mul_b);
        end
        if (cmd.gcd_init)
        begin
            neg_reg <= n_sign[WIDTH-1];
            nm_reg  <= n_mag;
            dm_reg  <= d_sign;
            u_reg   <= n_mag;
            v_reg   <= d_sign;
            k_reg   <= '0;
        end
        else if (cmd.gcd_step)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
            k_reg <= k_next;
        end
        if (cmd.div_init)
        begin
            g_reg    <= (u_reg | v_reg) << k_reg;
            rem1_reg <= '0;
            rem2_reg <= '0;
            q1_reg   <= nm_reg;
            q2_reg   <= dm_reg;
        end
        else if (cmd.div_step)
        begin
            rem1_reg <= rem1_next;
            rem2_reg <= rem2_next;
            q1_reg   <= q1_next;
            q2_reg   <= q2_next;
        end
        if (cmd.out_load)
        begin
            res_num_reg <= 32'(rn_w);
            res_den_reg <= 32'(rd_w);
            truth_reg   <= tr_w;
            fault_reg   <= ft_w;
        end
    end

    assign sts.is_defined  = (op_reg <= rau_pkg::OP_SIMPLIFY);
    assign sts.is_simplify = (op_reg == rau_pkg::OP_SIMPLIFY);
    assign sts.trivial     = (an_reg == '0) || (ad_reg == '0) || (ad_reg == WIDTH'(1));
    assign sts.gcd_done    = (u_reg == '0) || (v_reg == '0);

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign truth   = truth_reg;
    assign fault   = fault_reg;

endmodule
